### rtl/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared types, codes and sizes for the multi-queue message fifo.
// ----------------------------------------------------------------------------
package mqf_pkg;

   localparam int NUM_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int HANDLE_BITS = 32;

   localparam int KIND_W   = 2;
   localparam int QID_W    = 3;
   localparam int MSG_W    = 32;
   localparam int STATUS_W = 2;

   localparam int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int SLOT_COUNT = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W     = $clog2(SLOT_COUNT);

   // operation codes
   localparam logic [KIND_W-1:0] OP_OPEN  = 2'd0;
   localparam logic [KIND_W-1:0] OP_SEND  = 2'd1;
   localparam logic [KIND_W-1:0] OP_RECV  = 2'd2;
   localparam logic [KIND_W-1:0] OP_CLOSE = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [QID_W-1:0]  queue_id;
      logic [MSG_W-1:0]  message_handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MSG_W-1:0]    handle_out;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic [KIND_W-1:0]      op;
      logic                   bad_queue;
      logic [QIDX_W-1:0]      qidx;
      logic [HANDLE_BITS-1:0] handle;
   } cmd_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

### rtl/mqf_front.sv
// ----------------------------------------------------------------------------
// mqf_front
// Accepts request transactions, classifies them and buffers them in a
// two-entry command queue for the execution side.
// ----------------------------------------------------------------------------
module mqf_front
   import mqf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    slots_ff [2];
   logic       wr_sel_ff, wr_sel_in;
   logic       rd_sel_ff, rd_sel_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd_new;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slots_ff[rd_sel_ff];

   always_comb begin
      cmd_new.op        = req_data.kind;
      // ids past the last queue behave as a queue that is never open
      cmd_new.bad_queue = (32'(req_data.queue_id) >= 32'(NUM_QUEUES));
      cmd_new.qidx      = QIDX_W'(req_data.queue_id);
      cmd_new.handle    = HANDLE_BITS'(req_data.message_handle);
   end

   always_comb begin
      wr_sel_in = push ? ~wr_sel_ff : wr_sel_ff;
      rd_sel_in = cmd_pop ? ~rd_sel_ff : rd_sel_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_sel_ff <= wr_sel_in;
         rd_sel_ff <= rd_sel_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_sel_ff] <= cmd_new;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("command queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("pop from empty command queue");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !cmd_pop |=> cmd_valid)
      else $error("pushed command not visible");

endmodule

### rtl/mqf_back.sv
// ----------------------------------------------------------------------------
// mqf_back
// Executes queue commands: open mask, per-queue pointers, message slot
// memory and the response register.
// ----------------------------------------------------------------------------
module mqf_back
   import mqf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [NUM_QUEUES-1:0] open_mask_ff, open_mask_in;
   logic [PTR_W-1:0]      wr_idx_ff [NUM_QUEUES];
   logic [PTR_W-1:0]      rd_idx_ff [NUM_QUEUES];
   logic [PTR_W-1:0]      wr_idx_in, rd_idx_in;
   logic                  wr_upd, rd_upd;

   logic [HANDLE_BITS-1:0] slot_mem [SLOT_COUNT];
   logic [HANDLE_BITS-1:0] rd_data_ff;
   logic                   mem_we, mem_re;
   logic [ADDR_W-1:0]      mem_waddr, mem_raddr;

   logic                pend_valid_ff, pend_valid_in;
   logic [STATUS_W-1:0] pend_status_ff;
   logic                pend_recv_ok_ff;
   logic                pend_move;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   logic [STATUS_W-1:0] status;
   logic                recv_ok;
   logic                q_open;
   logic [PTR_W-1:0]    w_cur, r_cur;
   logic [ADDR_W-1:0]   q_base;

   assign pend_move = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign cmd_pop   = cmd_valid && (!pend_valid_ff || pend_move);

   assign q_open = open_mask_ff[cmd.qidx];
   assign w_cur  = wr_idx_ff[cmd.qidx];
   assign r_cur  = rd_idx_ff[cmd.qidx];
   assign q_base = ADDR_W'(cmd.qidx) * ADDR_W'(QUEUE_DEPTH);

   assign mem_waddr = q_base + ADDR_W'(w_cur);
   assign mem_raddr = q_base + ADDR_W'(r_cur);

   always_comb begin
      status       = ST_OK;
      recv_ok      = 1'b0;
      open_mask_in = open_mask_ff;
      wr_idx_in    = w_cur;
      rd_idx_in    = r_cur;
      wr_upd       = 1'b0;
      rd_upd       = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      priority if (cmd.bad_queue) begin
         status = ST_CLOSED;
      end else if (cmd.op == OP_OPEN) begin
         // reopening an open queue keeps its contents
         if (!q_open) begin
            wr_idx_in = '0;
            rd_idx_in = '0;
            wr_upd    = 1'b1;
            rd_upd    = 1'b1;
            open_mask_in[cmd.qidx] = 1'b1;
         end
      end else if (!q_open) begin
         status = ST_CLOSED;
      end else begin
         unique case (cmd.op)
            OP_SEND: begin
               // one slot always left free
               if (next_ptr(w_cur) == r_cur) begin
                  status = ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  wr_idx_in = next_ptr(w_cur);
                  wr_upd    = 1'b1;
               end
            end
            OP_RECV: begin
               if (r_cur == w_cur) begin
                  status = ST_EMPTY;
               end else begin
                  mem_re    = 1'b1;
                  recv_ok   = 1'b1;
                  rd_idx_in = next_ptr(r_cur);
                  rd_upd    = 1'b1;
               end
            end
            default: begin
               open_mask_in[cmd.qidx] = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_mask_ff <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            wr_idx_ff[i] <= '0;
            rd_idx_ff[i] <= '0;
         end
      end else if (cmd_pop) begin
         open_mask_ff <= open_mask_in;
         if (wr_upd) begin
            wr_idx_ff[cmd.qidx] <= wr_idx_in;
         end
         if (rd_upd) begin
            rd_idx_ff[cmd.qidx] <= rd_idx_in;
         end
      end
   end

   // message slot memory, read data registered
   always_ff @(posedge clock) begin
      if (cmd_pop && mem_we) begin
         slot_mem[mem_waddr] <= cmd.handle;
      end
      if (cmd_pop && mem_re) begin
         rd_data_ff <= slot_mem[mem_raddr];
      end
   end

   assign pend_valid_in = cmd_pop || (pend_valid_ff && !pend_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         pend_status_ff  <= status;
         pend_recv_ok_ff <= recv_ok;
      end
   end

   assign rsp_valid_in = pend_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_data_ff.status     <= pend_status_ff;
         rsp_data_ff.handle_out <= pend_recv_ok_ff ? MSG_W'(rd_data_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pend_holds: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !pend_move |=> pend_valid_ff)
      else $error("pending result lost");

   a_recv_tracked: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && recv_ok |=> pend_valid_ff && pend_recv_ok_ff)
      else $error("receive result not staged");

   a_recv_status: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && recv_ok |=> pend_status_ff == ST_OK)
      else $error("successful receive with bad status");

   a_no_rw_both: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("slot write and read in one command");

endmodule

### rtl/multi_queue_message_fifo_core.sv
// A request passes the command queue, the pending result stage and the response register.
// Throughput: one transaction per cycle while the response side does not stall.
// The rate is set by the execute stage, one command a cycle with at most one slot access.
// Reset clears the open marks, queue pointers and all handshake state at once;
// the message slot memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// multi_queue_message_fifo_core
// Bank of circular message queues with open, send, receive and close commands.
// ----------------------------------------------------------------------------
module multi_queue_message_fifo_core
   import mqf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   mqf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   mqf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
